/* hdl/i2cmbc_pkg.sv */
// Shared codes and reset values for the I2C master byte controller.
package i2cmbc_pkg;

  localparam int unsigned HalfW = 16;
  localparam int unsigned TmoW  = 8;
  localparam int unsigned PhW   = 4;
  localparam int unsigned BcW   = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned OpW   = 3;
  localparam int unsigned CfgAddrW = 8;

  localparam logic [HalfW-1:0] HALF_RST = 16'd20;
  localparam logic [TmoW-1:0]  TMO_RST  = 8'd250;

  localparam logic [CfgAddrW-1:0] REG_HALF_PERIOD = 8'd0;
  localparam logic [CfgAddrW-1:0] REG_ACK_TIMEOUT = 8'd1;

  localparam logic [OpW-1:0] OP_START    = 3'd0;
  localparam logic [OpW-1:0] OP_STOP     = 3'd1;
  localparam logic [OpW-1:0] OP_WRITE    = 3'd2;
  localparam logic [OpW-1:0] OP_WAIT_ACK = 3'd3;
  localparam logic [OpW-1:0] OP_READ     = 3'd4;
  localparam logic [OpW-1:0] OP_SEND_ACK = 3'd5;

  localparam logic [PhW-1:0] PH_IDLE    = 4'd0;
  localparam logic [PhW-1:0] PH_ST_LOW  = 4'd1;
  localparam logic [PhW-1:0] PH_SP_HI   = 4'd2;
  localparam logic [PhW-1:0] PH_FIN     = 4'd3;
  localparam logic [PhW-1:0] PH_END     = 4'd4;
  localparam logic [PhW-1:0] PH_W_BIT   = 4'd5;
  localparam logic [PhW-1:0] PH_W_HI    = 4'd6;
  localparam logic [PhW-1:0] PH_W_LO    = 4'd7;
  localparam logic [PhW-1:0] PH_WA_CLK  = 4'd8;
  localparam logic [PhW-1:0] PH_WA_POLL = 4'd9;
  localparam logic [PhW-1:0] PH_RD_LO   = 4'd10;
  localparam logic [PhW-1:0] PH_RD_HI   = 4'd11;
  localparam logic [PhW-1:0] PH_AK_LOW  = 4'd12;
  localparam logic [PhW-1:0] PH_AK_HI   = 4'd13;

  localparam logic [BcW-1:0] BITS_PER_BYTE = 4'd8;

endpackage

/* hdl/i2c_master_byte_controller_top.sv */
// I2C master byte controller: tick-driven SCL/SDA sequencer with config port.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | cmd_valid, operation, tx_byte, ack_bit, sda_in
//  out     | out_valid/out_stall| scl_level, sda_out, sda_drive, busy_res,
//          |                    | done_res, rx_byte, no_ack
//  cfg     | cfg_valid/cfg_ready| cfg_addr, cfg_data
//
// One tick per clock while the result is not stalled: a tick is held in the input
// register, then its sequencer step is taken into the result register.
// The sequencer step is one pass of logic from the state registers.
// Reset: phase idle, SCL/SDA high and driven, half period 20, timeout 250.
// A stalled result holds the input register; the next tick still enters
// while the result register is free or being taken.
module i2c_master_byte_controller_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd_valid,
  input  logic [i2cmbc_pkg::OpW-1:0]         in_operation,
  input  logic [i2cmbc_pkg::ByteW-1:0]       in_tx_byte,
  input  logic                               in_ack_bit,
  input  logic                               in_sda_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_scl_level,
  output logic                               out_sda_out,
  output logic                               out_sda_drive,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic [i2cmbc_pkg::ByteW-1:0]       out_rx_byte,
  output logic                               out_no_ack,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cmbc_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [i2cmbc_pkg::HalfW-1:0]       cfg_data
);

  logic [i2cmbc_pkg::HalfW-1:0] half_r;
  logic [i2cmbc_pkg::TmoW-1:0]  tmo_r;

  logic                         in_v_r;
  logic                         cmdv_r;
  logic [i2cmbc_pkg::OpW-1:0]   op_r;
  logic [i2cmbc_pkg::ByteW-1:0] tx_r;
  logic                         ackin_r;
  logic                         sda_r;

  logic [i2cmbc_pkg::PhW-1:0]   phase_r, phase_nxt;
  logic [i2cmbc_pkg::BcW-1:0]   bc_r, bc_nxt;
  logic [i2cmbc_pkg::ByteW-1:0] shift_r, shift_nxt;
  logic [i2cmbc_pkg::HalfW-1:0] delay_r, delay_nxt;
  logic [i2cmbc_pkg::TmoW-1:0]  poll_r, poll_nxt;
  logic [i2cmbc_pkg::ByteW-1:0] rx_r, rx_nxt;
  logic                         scl_r, scl_nxt;
  logic                         sdo_r, sdo_nxt;
  logic                         drv_r, drv_nxt;
  logic                         noack_r, noack_nxt;
  logic                         ackl_r, ackl_nxt;
  logic                         done_nxt;

  logic                         out_v_r;
  logic                         o_scl_r, o_sdo_r, o_drv_r, o_busy_r, o_done_r, o_noack_r;
  logic [i2cmbc_pkg::ByteW-1:0] o_rx_r;

  logic                         advance;
  logic                         taken;
  logic [i2cmbc_pkg::HalfW-1:0] full_w;
  logic [i2cmbc_pkg::HalfW-1:0] half_w;
  logic [i2cmbc_pkg::TmoW:0]    poll_inc;
  logic [i2cmbc_pkg::BcW-1:0]   bc_inc;
  logic [i2cmbc_pkg::ByteW-1:0] shift_in;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;
  assign cfg_ready = 1'b1;

  assign full_w = (half_r == '0) ? i2cmbc_pkg::HalfW'(1) : half_r;
  assign half_w = ((half_r >> 1) == '0) ? i2cmbc_pkg::HalfW'(1) : (half_r >> 1);

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    shift_nxt = shift_r;
    delay_nxt = delay_r;
    poll_nxt  = poll_r;
    rx_nxt    = rx_r;
    scl_nxt   = scl_r;
    sdo_nxt   = sdo_r;
    drv_nxt   = drv_r;
    noack_nxt = noack_r;
    ackl_nxt  = ackl_r;
    done_nxt  = 1'b0;
    poll_inc  = '0;
    bc_inc    = '0;
    shift_in  = '0;

    taken = (phase_r == i2cmbc_pkg::PH_IDLE) && cmdv_r &&
            (op_r <= i2cmbc_pkg::OP_SEND_ACK);

    if (taken) begin
      unique case (op_r)
        i2cmbc_pkg::OP_START: begin
          drv_nxt = 1'b1; sdo_nxt = 1'b1; scl_nxt = 1'b1;
          phase_nxt = i2cmbc_pkg::PH_ST_LOW; delay_nxt = full_w;
        end
        i2cmbc_pkg::OP_STOP: begin
          drv_nxt = 1'b1; scl_nxt = 1'b0; sdo_nxt = 1'b0;
          phase_nxt = i2cmbc_pkg::PH_SP_HI; delay_nxt = full_w;
        end
        i2cmbc_pkg::OP_WRITE: begin
          drv_nxt = 1'b1; scl_nxt = 1'b0;
          shift_nxt = tx_r; bc_nxt = '0;
          phase_nxt = i2cmbc_pkg::PH_W_BIT; delay_nxt = '0;
        end
        i2cmbc_pkg::OP_WAIT_ACK: begin
          noack_nxt = 1'b0; sdo_nxt = 1'b1; drv_nxt = 1'b0;
          phase_nxt = i2cmbc_pkg::PH_WA_CLK; delay_nxt = half_w;
        end
        i2cmbc_pkg::OP_READ: begin
          drv_nxt = 1'b0; shift_nxt = '0; bc_nxt = '0; ackl_nxt = ackin_r;
          phase_nxt = i2cmbc_pkg::PH_RD_LO; delay_nxt = '0;
        end
        default: begin
          ackl_nxt = ackin_r;
          phase_nxt = i2cmbc_pkg::PH_AK_LOW; delay_nxt = '0;
        end
      endcase
    end else if (phase_r != i2cmbc_pkg::PH_IDLE && delay_r != '0) begin
      delay_nxt = delay_r - i2cmbc_pkg::HalfW'(1);
    end

    if (phase_nxt != i2cmbc_pkg::PH_IDLE && delay_nxt == '0) begin
      bc_inc   = bc_nxt + i2cmbc_pkg::BcW'(1);
      poll_inc = {1'b0, poll_nxt} + (i2cmbc_pkg::TmoW+1)'(1);
      shift_in = {shift_nxt[i2cmbc_pkg::ByteW-2:0], sda_r};
      unique case (phase_nxt)
        i2cmbc_pkg::PH_ST_LOW: begin
          sdo_nxt = 1'b0; phase_nxt = i2cmbc_pkg::PH_END; delay_nxt = full_w;
        end
        i2cmbc_pkg::PH_SP_HI: begin
          scl_nxt = 1'b1; sdo_nxt = 1'b1;
          phase_nxt = i2cmbc_pkg::PH_FIN; delay_nxt = full_w;
        end
        i2cmbc_pkg::PH_FIN: begin
          phase_nxt = i2cmbc_pkg::PH_IDLE; delay_nxt = '0; done_nxt = 1'b1;
        end
        i2cmbc_pkg::PH_END: begin
          scl_nxt = 1'b0;
          phase_nxt = i2cmbc_pkg::PH_IDLE; delay_nxt = '0; done_nxt = 1'b1;
        end
        i2cmbc_pkg::PH_W_BIT: begin
          if (bc_nxt >= i2cmbc_pkg::BITS_PER_BYTE) begin
            phase_nxt = i2cmbc_pkg::PH_END; delay_nxt = full_w;
          end else begin
            sdo_nxt = shift_nxt[i2cmbc_pkg::ByteW-1];
            shift_nxt = {shift_nxt[i2cmbc_pkg::ByteW-2:0], 1'b0};
            phase_nxt = i2cmbc_pkg::PH_W_HI; delay_nxt = full_w;
          end
        end
        i2cmbc_pkg::PH_W_HI: begin
          scl_nxt = 1'b1; phase_nxt = i2cmbc_pkg::PH_W_LO; delay_nxt = full_w;
        end
        i2cmbc_pkg::PH_W_LO: begin
          scl_nxt = 1'b0; bc_nxt = bc_inc;
          phase_nxt = i2cmbc_pkg::PH_W_BIT; delay_nxt = full_w;
        end
        i2cmbc_pkg::PH_WA_CLK: begin
          scl_nxt = 1'b1; poll_nxt = '0;
          phase_nxt = i2cmbc_pkg::PH_WA_POLL; delay_nxt = half_w;
        end
        i2cmbc_pkg::PH_WA_POLL: begin
          if (!sda_r) begin
            scl_nxt = 1'b0;
            phase_nxt = i2cmbc_pkg::PH_IDLE; delay_nxt = '0; done_nxt = 1'b1;
          end else if (poll_inc > {1'b0, tmo_r}) begin
            noack_nxt = 1'b1;
            drv_nxt = 1'b1; scl_nxt = 1'b0; sdo_nxt = 1'b0;
            phase_nxt = i2cmbc_pkg::PH_SP_HI; delay_nxt = full_w;
          end else begin
            poll_nxt = poll_inc[i2cmbc_pkg::TmoW-1:0];
            delay_nxt = i2cmbc_pkg::HalfW'(1);
          end
        end
        i2cmbc_pkg::PH_RD_LO: begin
          scl_nxt = 1'b0; phase_nxt = i2cmbc_pkg::PH_RD_HI; delay_nxt = full_w;
        end
        i2cmbc_pkg::PH_RD_HI: begin
          scl_nxt = 1'b1; shift_nxt = shift_in; bc_nxt = bc_inc;
          delay_nxt = full_w;
          if (bc_inc >= i2cmbc_pkg::BITS_PER_BYTE) begin
            rx_nxt = shift_in; phase_nxt = i2cmbc_pkg::PH_AK_LOW;
          end else begin
            phase_nxt = i2cmbc_pkg::PH_RD_LO;
          end
        end
        i2cmbc_pkg::PH_AK_LOW: begin
          scl_nxt = 1'b0; drv_nxt = 1'b1; sdo_nxt = !ackl_nxt;
          phase_nxt = i2cmbc_pkg::PH_AK_HI; delay_nxt = full_w;
        end
        i2cmbc_pkg::PH_AK_HI: begin
          scl_nxt = 1'b1; phase_nxt = i2cmbc_pkg::PH_END; delay_nxt = full_w;
        end
        default: begin
          phase_nxt = i2cmbc_pkg::PH_IDLE; delay_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= i2cmbc_pkg::HALF_RST;
      tmo_r  <= i2cmbc_pkg::TMO_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_addr == i2cmbc_pkg::REG_HALF_PERIOD) begin
        half_r <= cfg_data;
      end else if (cfg_addr == i2cmbc_pkg::REG_ACK_TIMEOUT) begin
        tmo_r <= cfg_data[i2cmbc_pkg::TmoW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmdv_r  <= in_cmd_valid;
      op_r    <= in_operation;
      tx_r    <= in_tx_byte;
      ackin_r <= in_ack_bit;
      sda_r   <= in_sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cmbc_pkg::PH_IDLE;
      bc_r    <= '0;
      shift_r <= '0;
      delay_r <= '0;
      poll_r  <= '0;
      rx_r    <= '0;
      scl_r   <= 1'b1;
      sdo_r   <= 1'b1;
      drv_r   <= 1'b1;
      noack_r <= 1'b0;
      ackl_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      shift_r <= shift_nxt;
      delay_r <= delay_nxt;
      poll_r  <= poll_nxt;
      rx_r    <= rx_nxt;
      scl_r   <= scl_nxt;
      sdo_r   <= sdo_nxt;
      drv_r   <= drv_nxt;
      noack_r <= noack_nxt;
      ackl_r  <= ackl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_scl_r   <= scl_nxt;
      o_sdo_r   <= sdo_nxt;
      o_drv_r   <= drv_nxt;
      o_busy_r  <= (phase_nxt != i2cmbc_pkg::PH_IDLE);
      o_done_r  <= done_nxt;
      o_rx_r    <= rx_nxt;
      o_noack_r <= noack_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_scl_level = o_scl_r;
  assign out_sda_out   = o_sdo_r;
  assign out_sda_drive = o_drv_r;
  assign out_busy_res  = o_busy_r;
  assign out_done_res  = o_done_r;
  assign out_rx_byte   = o_rx_r;
  assign out_no_ack    = o_noack_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_done_r |-> !o_busy_r)
    else $error("done and busy reported together");

  a_active_has_delay: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != i2cmbc_pkg::PH_IDLE |-> delay_r != '0)
    else $error("active phase with expired delay");

  a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2cmbc_pkg::PH_IDLE |-> delay_r == '0)
    else $error("idle phase with pending delay");

  a_release_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !drv_r |-> (phase_r == i2cmbc_pkg::PH_IDLE || phase_r == i2cmbc_pkg::PH_WA_CLK ||
                phase_r == i2cmbc_pkg::PH_WA_POLL || phase_r == i2cmbc_pkg::PH_RD_LO ||
                phase_r == i2cmbc_pkg::PH_RD_HI || phase_r == i2cmbc_pkg::PH_AK_LOW ||
                phase_r == i2cmbc_pkg::PH_END))
    else $error("SDA released outside a receive phase");

endmodule

/* tb/tb_i2c_master_byte_controller_top.sv */
// Self-checking testbench for the tick-driven I2C master byte controller.
module tb_i2c_master_byte_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                               cmd_valid;
    logic [i2cmbc_pkg::OpW-1:0]         op;
    logic [i2cmbc_pkg::ByteW-1:0]       tx;
    logic                               ack;
    logic                               sda;
  } tick_t;

  typedef struct packed {
    logic [i2cmbc_pkg::PhW-1:0]         phase;
    logic [i2cmbc_pkg::OpW-1:0]         op;
    logic [i2cmbc_pkg::BcW-1:0]         bits;
    logic [i2cmbc_pkg::ByteW-1:0]       shreg;
    logic [i2cmbc_pkg::HalfW-1:0]       dly;
    logic [i2cmbc_pkg::TmoW-1:0]        polls;
    logic [i2cmbc_pkg::ByteW-1:0]       rx;
    logic                               scl;
    logic                               sda;
    logic                               drv;
    logic [1:0]                         flags;
    logic                               done;
  } bus_state_t;

  typedef struct packed {
    logic                               scl;
    logic                               sda;
    logic                               drv;
    logic                               busy;
    logic                               done;
    logic [i2cmbc_pkg::ByteW-1:0]       rx;
    logic                               nack;
  } pins_t;

  typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_t;

  localparam logic [i2cmbc_pkg::CfgAddrW-1:0] REG_UNUSED = 8'd2;
  localparam logic [i2cmbc_pkg::OpW-1:0]      OP_BAD_LO  = 3'd6;
  localparam logic [i2cmbc_pkg::OpW-1:0]      OP_BAD_HI  = 3'd7;
  localparam int                              RAND_PHASES = 3;
  localparam int                              TICKS_PER_PHASE = 100;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                in_cmd_valid = 1'b0;
  logic [i2cmbc_pkg::OpW-1:0]          in_operation = '0;
  logic [i2cmbc_pkg::ByteW-1:0]        in_tx_byte = '0;
  logic                                in_ack_bit = 1'b0;
  logic                                in_sda_in = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                out_scl_level;
  logic                                out_sda_out;
  logic                                out_sda_drive;
  logic                                out_busy_res;
  logic                                out_done_res;
  logic [i2cmbc_pkg::ByteW-1:0]        out_rx_byte;
  logic                                out_no_ack;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [i2cmbc_pkg::CfgAddrW-1:0]     cfg_addr = '0;
  logic [i2cmbc_pkg::HalfW-1:0]        cfg_data = '0;

  i2c_master_byte_controller_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd_valid  (in_cmd_valid),
    .in_operation  (in_operation),
    .in_tx_byte    (in_tx_byte),
    .in_ack_bit    (in_ack_bit),
    .in_sda_in     (in_sda_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_out   (out_sda_out),
    .out_sda_drive (out_sda_drive),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rx_byte   (out_rx_byte),
    .out_no_ack    (out_no_ack),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  tick_t                          tick_q[$];
  pins_t                          expected_pins_q[$];
  bus_state_t                     live_state;
  bus_state_t                     gen_state;
  logic [i2cmbc_pkg::HalfW-1:0]   half_cfg = i2cmbc_pkg::HALF_RST;
  logic [i2cmbc_pkg::TmoW-1:0]    tmo_cfg = i2cmbc_pkg::TMO_RST;
  logic                           tick_accepted = 1'b0;
  int                             ticks_queued = 0;
  int                             ticks_sent = 0;
  int                             cmds_issued = 0;
  int                             errors = 0;
  int                             send_idle_pct = 0;
  int                             stall_pct = 0;
  int                             busy_noise_pct = 0;
  int                             drop_pct = 0;

  function automatic pins_t bus_step(inout bus_state_t s, input tick_t t,
                                     input logic [i2cmbc_pkg::HalfW-1:0] half,
                                     input logic [i2cmbc_pkg::TmoW-1:0] tmo);
    logic [i2cmbc_pkg::HalfW-1:0] full_w;
    logic [i2cmbc_pkg::HalfW-1:0] half_w;
    logic [i2cmbc_pkg::TmoW:0]    n;
    logic                         taken;
    pins_t                        r;
    full_w = (half == '0) ? 16'd1 : half;
    half_w = (half[i2cmbc_pkg::HalfW-1:1] == '0) ? 16'd1
                                                : {1'b0, half[i2cmbc_pkg::HalfW-1:1]};
    taken = 1'b0;
    s.done = 1'b0;
    if (s.phase == i2cmbc_pkg::PH_IDLE && t.cmd_valid && t.op <= i2cmbc_pkg::OP_SEND_ACK) begin
      taken = 1'b1;
      s.op = t.op;
      case (t.op)
        i2cmbc_pkg::OP_START: begin
          s.drv = 1'b1; s.sda = 1'b1; s.scl = 1'b1;
          s.phase = i2cmbc_pkg::PH_ST_LOW; s.dly = full_w;
        end
        i2cmbc_pkg::OP_STOP: begin
          s.drv = 1'b1; s.scl = 1'b0; s.sda = 1'b0;
          s.phase = i2cmbc_pkg::PH_SP_HI; s.dly = full_w;
        end
        i2cmbc_pkg::OP_WRITE: begin
          s.drv = 1'b1; s.scl = 1'b0; s.shreg = t.tx; s.bits = '0;
          s.phase = i2cmbc_pkg::PH_W_BIT; s.dly = '0;
        end
        i2cmbc_pkg::OP_WAIT_ACK: begin
          s.flags[0] = 1'b0; s.sda = 1'b1; s.drv = 1'b0;
          s.phase = i2cmbc_pkg::PH_WA_CLK; s.dly = half_w;
        end
        i2cmbc_pkg::OP_READ: begin
          s.drv = 1'b0; s.shreg = '0; s.bits = '0; s.flags[1] = t.ack;
          s.phase = i2cmbc_pkg::PH_RD_LO; s.dly = '0;
        end
        default: begin
          s.flags[1] = t.ack;
          s.phase = i2cmbc_pkg::PH_AK_LOW; s.dly = '0;
        end
      endcase
    end
    if (!taken && s.phase != i2cmbc_pkg::PH_IDLE && s.dly != '0) s.dly = s.dly - 1'b1;
    while (s.phase != i2cmbc_pkg::PH_IDLE && s.dly == '0) begin
      case (s.phase)
        i2cmbc_pkg::PH_ST_LOW: begin
          s.sda = 1'b0; s.phase = i2cmbc_pkg::PH_END; s.dly = full_w;
        end
        i2cmbc_pkg::PH_SP_HI: begin
          s.scl = 1'b1; s.sda = 1'b1; s.phase = i2cmbc_pkg::PH_FIN; s.dly = full_w;
        end
        i2cmbc_pkg::PH_FIN: begin
          s.phase = i2cmbc_pkg::PH_IDLE; s.dly = '0; s.done = 1'b1;
        end
        i2cmbc_pkg::PH_END: begin
          s.scl = 1'b0; s.phase = i2cmbc_pkg::PH_IDLE; s.dly = '0; s.done = 1'b1;
        end
        i2cmbc_pkg::PH_W_BIT: begin
          if (s.bits >= i2cmbc_pkg::BITS_PER_BYTE) begin
            s.phase = i2cmbc_pkg::PH_END; s.dly = full_w;
          end else begin
            s.sda = s.shreg[i2cmbc_pkg::ByteW-1];
            s.shreg = s.shreg << 1;
            s.phase = i2cmbc_pkg::PH_W_HI; s.dly = full_w;
          end
        end
        i2cmbc_pkg::PH_W_HI: begin
          s.scl = 1'b1; s.phase = i2cmbc_pkg::PH_W_LO; s.dly = full_w;
        end
        i2cmbc_pkg::PH_W_LO: begin
          s.scl = 1'b0; s.bits = s.bits + 1'b1;
          s.phase = i2cmbc_pkg::PH_W_BIT; s.dly = full_w;
        end
        i2cmbc_pkg::PH_WA_CLK: begin
          s.scl = 1'b1; s.polls = '0; s.phase = i2cmbc_pkg::PH_WA_POLL; s.dly = half_w;
        end
        i2cmbc_pkg::PH_WA_POLL: begin
          if (!t.sda) begin
            s.phase = i2cmbc_pkg::PH_END; s.dly = '0;
          end else begin
            n = {1'b0, s.polls} + 1'b1;
            if (n > {1'b0, tmo}) begin
              s.flags[0] = 1'b1;
              s.drv = 1'b1; s.scl = 1'b0; s.sda = 1'b0;
              s.phase = i2cmbc_pkg::PH_SP_HI; s.dly = full_w;
            end else begin
              s.polls = n[i2cmbc_pkg::TmoW-1:0];
              s.phase = i2cmbc_pkg::PH_WA_POLL; s.dly = 16'd1;
            end
          end
        end
        i2cmbc_pkg::PH_RD_LO: begin
          s.scl = 1'b0; s.phase = i2cmbc_pkg::PH_RD_HI; s.dly = full_w;
        end
        i2cmbc_pkg::PH_RD_HI: begin
          s.scl = 1'b1;
          s.shreg = {s.shreg[i2cmbc_pkg::ByteW-2:0], t.sda};
          s.bits = s.bits + 1'b1;
          if (s.bits >= i2cmbc_pkg::BITS_PER_BYTE) begin
            s.rx = s.shreg; s.phase = i2cmbc_pkg::PH_AK_LOW; s.dly = full_w;
          end else begin
            s.phase = i2cmbc_pkg::PH_RD_LO; s.dly = full_w;
          end
        end
        i2cmbc_pkg::PH_AK_LOW: begin
          s.scl = 1'b0; s.drv = 1'b1; s.sda = !s.flags[1];
          s.phase = i2cmbc_pkg::PH_AK_HI; s.dly = full_w;
        end
        i2cmbc_pkg::PH_AK_HI: begin
          s.scl = 1'b1; s.phase = i2cmbc_pkg::PH_END; s.dly = full_w;
        end
        default: begin
          s.phase = i2cmbc_pkg::PH_IDLE; s.dly = '0;
        end
      endcase
    end
    r.scl  = s.scl;
    r.sda  = s.sda;
    r.drv  = s.drv;
    r.busy = (s.phase != i2cmbc_pkg::PH_IDLE);
    r.done = s.done;
    r.rx   = s.rx;
    r.nack = s.flags[0];
    return r;
  endfunction

  function automatic logic pick_sda(input sda_mode_t mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return (gen_state.phase == i2cmbc_pkg::PH_WA_POLL) ?
                       ($urandom_range(5) != 0) : 1'($urandom_range(1));
    endcase
  endfunction

  task automatic push_tick(input logic v, input logic [i2cmbc_pkg::OpW-1:0] op,
                           input logic [i2cmbc_pkg::ByteW-1:0] tx, input logic ack,
                           input logic sda);
    tick_t t;
    t = {v, op, tx, ack, sda};
    void'(bus_step(gen_state, t, half_cfg, tmo_cfg));
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  task automatic run_command(input logic [i2cmbc_pkg::OpW-1:0] op,
                             input logic [i2cmbc_pkg::ByteW-1:0] tx,
                             input logic ack, input sda_mode_t mode);
    int   gap;
    logic busy;
    if ($urandom_range(99) < drop_pct) return;
    cmds_issued++;
    push_tick(1'b1, op, tx, ack, pick_sda(mode));
    gap = $urandom_range(2);
    while (gen_state.phase != i2cmbc_pkg::PH_IDLE || gap > 0) begin
      busy = (gen_state.phase != i2cmbc_pkg::PH_IDLE);
      push_tick(busy && ($urandom_range(99) < busy_noise_pct), 3'($urandom_range(7)),
                8'($urandom_range(255)), 1'($urandom_range(1)), pick_sda(mode));
      if (!busy) gap--;
    end
  endtask

  task automatic play_transfer();
    logic                         rd;
    logic [i2cmbc_pkg::ByteW-1:0] addr;
    int                           n;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: push_tick(1'b1, $urandom_range(1) ? OP_BAD_HI : OP_BAD_LO,
                     8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        1: run_command(i2cmbc_pkg::OP_SEND_ACK, 8'($urandom_range(255)),
                       1'($urandom_range(1)), SDA_RAND);
        2: run_command(i2cmbc_pkg::OP_STOP, 8'($urandom_range(255)),
                       1'($urandom_range(1)), SDA_RAND);
        default: repeat ($urandom_range(1, 6))
          push_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      endcase
    end else begin
      rd = 1'($urandom_range(1));
      n = $urandom_range(1, 3);
      addr = 8'($urandom_range(255));
      addr[0] = rd;
      run_command(i2cmbc_pkg::OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  SDA_RAND);
      run_command(i2cmbc_pkg::OP_WRITE, addr, 1'($urandom_range(1)), SDA_RAND);
      run_command(i2cmbc_pkg::OP_WAIT_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  SDA_RAND);
      for (int i = 0; i < n; i++) begin
        if (rd) begin
          run_command(i2cmbc_pkg::OP_READ, 8'($urandom_range(255)), i < n - 1, SDA_RAND);
        end else begin
          run_command(i2cmbc_pkg::OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      SDA_RAND);
          run_command(i2cmbc_pkg::OP_WAIT_ACK, 8'($urandom_range(255)),
                      1'($urandom_range(1)), SDA_RAND);
        end
      end
      run_command(i2cmbc_pkg::OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  SDA_RAND);
    end
  endtask

  task automatic write_reg(input logic [i2cmbc_pkg::CfgAddrW-1:0] addr,
                           input logic [i2cmbc_pkg::HalfW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (addr == i2cmbc_pkg::REG_HALF_PERIOD) half_cfg = data;
    else if (addr == i2cmbc_pkg::REG_ACK_TIMEOUT) tmo_cfg = data[i2cmbc_pkg::TmoW-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ticks_sent != ticks_queued || expected_pins_q.size() != 0) @(negedge clk);
  endtask

  task automatic begin_phase(input logic [i2cmbc_pkg::HalfW-1:0] half,
                             input logic [i2cmbc_pkg::HalfW-1:0] tmo);
    wait_drained();
    write_reg(i2cmbc_pkg::REG_HALF_PERIOD, half);
    write_reg(i2cmbc_pkg::REG_ACK_TIMEOUT, tmo);
    gen_state = live_state;
  endtask

  task automatic report(input string name, input logic [i2cmbc_pkg::ByteW-1:0] want,
                        input logic [i2cmbc_pkg::ByteW-1:0] got);
    if (want !== got) begin
      if (errors < 40)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin : accept_tick
    tick_t seen;
    tick_accepted = rst_n && in_valid && !in_stall;
    if (tick_accepted) begin
      seen = {in_cmd_valid, in_operation, in_tx_byte, in_ack_bit, in_sda_in};
      expected_pins_q.push_back(bus_step(live_state, seen, half_cfg, tmo_cfg));
      ticks_sent++;
    end
  end

  always @(negedge clk) begin : drive_tick
    tick_t t;
    if (rst_n && (!in_valid || tick_accepted)) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        t = tick_q.pop_front();
        in_valid <= 1'b1;
        {in_cmd_valid, in_operation, in_tx_byte, in_ack_bit, in_sda_in} <= t;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin : check_pins
    pins_t want;
    pins_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_scl_level, out_sda_out, out_sda_drive, out_busy_res, out_done_res,
             out_rx_byte, out_no_ack};
      if (expected_pins_q.size() == 0) begin
        if (errors < 40)
          $display("%0t ns: unexpected result, expected none, actual %0h", $time, got);
        errors++;
      end else begin
        want = expected_pins_q.pop_front();
        report("scl_level", want.scl, got.scl);
        report("sda_out", want.sda, got.sda);
        report("sda_drive", want.drv, got.drv);
        report("busy_res", want.busy, got.busy);
        report("done_res", want.done, got.done);
        report("rx_byte", want.rx, got.rx);
        report("no_ack", want.nack, got.nack);
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    live_state = '0;
    live_state.scl = 1'b1;
    live_state.sda = 1'b1;
    live_state.drv = 1'b1;
    gen_state = live_state;
    send_idle_pct = 10;
    stall_pct = 20;
    busy_noise_pct = 10;
    drop_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_command(i2cmbc_pkg::OP_START, 8'($urandom_range(255)), 1'b0, SDA_RAND);
    run_command(i2cmbc_pkg::OP_WAIT_ACK, 8'($urandom_range(255)), 1'b0, SDA_LOW);
    run_command(i2cmbc_pkg::OP_STOP, 8'($urandom_range(255)), 1'b0, SDA_RAND);

    begin_phase(16'd0, 16'd0);
    write_reg(REG_UNUSED, 16'($urandom_range(65535)));
    run_command(i2cmbc_pkg::OP_START, 8'($urandom_range(255)), 1'b1, SDA_RAND);
    run_command(i2cmbc_pkg::OP_WRITE, 8'h00, 1'b1, SDA_RAND);
    run_command(i2cmbc_pkg::OP_WAIT_ACK, 8'($urandom_range(255)), 1'b1, SDA_HIGH);
    run_command(i2cmbc_pkg::OP_READ, 8'($urandom_range(255)), 1'b0, SDA_LOW);
    push_tick(1'b1, OP_BAD_LO, 8'($urandom_range(255)), 1'b1, 1'b1);
    push_tick(1'b1, OP_BAD_HI, 8'($urandom_range(255)), 1'b0, 1'b0);
    busy_noise_pct = 100;
    run_command(i2cmbc_pkg::OP_SEND_ACK, 8'($urandom_range(255)), 1'b1, SDA_RAND);
    busy_noise_pct = 10;

    begin_phase(16'd1, 16'h0002);
    run_command(i2cmbc_pkg::OP_WAIT_ACK, 8'($urandom_range(255)), 1'b0, SDA_HIGH);
    run_command(i2cmbc_pkg::OP_WAIT_ACK, 8'($urandom_range(255)), 1'b0, SDA_RAND);
    run_command(i2cmbc_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_RAND);
    run_command(i2cmbc_pkg::OP_READ, 8'($urandom_range(255)), 1'b1, SDA_RAND);
    run_command(i2cmbc_pkg::OP_STOP, 8'($urandom_range(255)), 1'b1, SDA_RAND);

    send_idle_pct = 0;
    stall_pct = 0;
    begin_phase(16'd3, 16'hFF01);
    run_command(i2cmbc_pkg::OP_SEND_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                SDA_RAND);
    run_command(i2cmbc_pkg::OP_WAIT_ACK, 8'($urandom_range(255)), 1'b0, SDA_HIGH);

    drop_pct = 5;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p * 3 / RAND_PHASES)
        0: begin send_idle_pct = 26; stall_pct = 67; end
        1: begin send_idle_pct = 67; stall_pct = 26; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      begin_phase(16'(($urandom_range(9) < 8) ? $urandom_range(0, 2) : 3),
                  {8'($urandom_range(255)),
                   8'(($urandom_range(9) < 6) ? $urandom_range(1, 12) :
                      ($urandom_range(9) < 8) ? $urandom_range(13, 254) : 255)});
      phase_end = ticks_queued + TICKS_PER_PHASE;
      while (ticks_queued < phase_end) play_transfer();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_pins_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
